// ===== rtl/core/mrdps_pkg.sv =====
// Shared types, widths and codes for the min range decrement prefix search block.
package mrdps_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned MaxQueries  = 1024;
  localparam int unsigned ValueW      = 20;
  localparam int unsigned SlotW       = 10;
  localparam int unsigned CntW        = 11;  // holds 0..1024
  localparam int unsigned KindW       = 2;
  localparam int unsigned CfgW        = 11;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned ResW        = 12;
  localparam int unsigned SumW        = 32;
  localparam int unsigned DiffDepth   = MaxElements + 1;

  typedef logic [CntW-1:0]          cnt_t;
  typedef logic [ValueW-1:0]        value_t;
  typedef logic [SlotW-1:0]         slot_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [ResW-1:0]   res_t;

  // Request kinds
  typedef enum logic [KindW-1:0] {
    KIND_LOAD_ELEM  = 2'd0,
    KIND_LOAD_QUERY = 2'd1,
    KIND_START      = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_ELEMENTS = 1'd0,
    CFG_NUM_QUERIES  = 1'd1
  } cfg_idx_e;

  // Stored range query
  typedef struct packed {
    slot_t  left;
    slot_t  right;
    value_t amount;
  } query_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_INIT       = 4'd1,
    OP_MID        = 4'd2,
    OP_CLEAR      = 4'd3,
    OP_QREAD      = 4'd4,
    OP_QSTAGE     = 4'd5,
    OP_LREAD      = 4'd6,
    OP_LWRITE     = 4'd7,
    OP_RREAD      = 4'd8,
    OP_RWRITE     = 4'd9,
    OP_SCAN_START = 4'd10,
    OP_SCAN       = 4'd11,
    OP_UPDATE     = 4'd12,
    OP_RESULT     = 4'd13
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;   // write the accepted request into the stores
  } cmd_t;

  typedef struct packed {
    logic bound_ok;      // lo <= hi
    logic clear_done;    // last difference entry cleared this cycle
    logic queries_done;  // all queries of the candidate applied
    logic skip;          // staged query subtracts nothing
    logic scan_done;     // prefix scan finished
  } status_t;

endpackage

// ===== rtl/core/mrdps_ctrl.sv =====
// Sequencer for loads, the binary search and each candidate check.
module mrdps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [mrdps_pkg::KindW-1:0] kind_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  mrdps_pkg::status_t     status_i,
  output mrdps_pkg::cmd_t        cmd_o
);
  import mrdps_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_INIT   = 14'b00000000000010,
    ST_BOUND  = 14'b00000000000100,
    ST_CLEAR  = 14'b00000000001000,
    ST_QREAD  = 14'b00000000010000,
    ST_QSTAGE = 14'b00000000100000,
    ST_LREAD  = 14'b00000001000000,
    ST_LWRITE = 14'b00000010000000,
    ST_RREAD  = 14'b00000100000000,
    ST_RWRITE = 14'b00001000000000,
    ST_SCAN   = 14'b00010000000000,
    ST_UPDATE = 14'b00100000000000,
    ST_DONE   = 14'b01000000000000,
    ST_SPARE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and command
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.load  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept && (kind_e'(kind_i) == KIND_START)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = ST_BOUND;
      end
      ST_BOUND: begin
        if (status_i.bound_ok) begin
          cmd_o.op = OP_MID;
          state_d  = ST_CLEAR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clear_done) begin
          state_d = ST_QREAD;
        end
      end
      ST_QREAD: begin
        if (status_i.queries_done) begin
          cmd_o.op = OP_SCAN_START;
          state_d  = ST_SCAN;
        end else begin
          cmd_o.op = OP_QREAD;
          state_d  = ST_QSTAGE;
        end
      end
      ST_QSTAGE: begin
        cmd_o.op = OP_QSTAGE;
        state_d  = status_i.skip ? ST_QREAD : ST_LREAD;
      end
      ST_LREAD: begin
        cmd_o.op = OP_LREAD;
        state_d  = ST_LWRITE;
      end
      ST_LWRITE: begin
        cmd_o.op = OP_LWRITE;
        state_d  = ST_RREAD;
      end
      ST_RREAD: begin
        cmd_o.op = OP_RREAD;
        state_d  = ST_RWRITE;
      end
      ST_RWRITE: begin
        cmd_o.op = OP_RWRITE;
        state_d  = ST_QREAD;
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (status_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = ST_BOUND;
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/mrdps_dp.sv =====
// Stores, difference array, prefix scan and search bounds.
module mrdps_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrdps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mrdps_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [mrdps_pkg::KindW-1:0]   kind_i,
  input  logic [mrdps_pkg::SlotW-1:0]   slot_i,
  input  logic [mrdps_pkg::ValueW-1:0]  value_i,
  input  logic [mrdps_pkg::SlotW-1:0]   range_left_i,
  input  logic [mrdps_pkg::SlotW-1:0]   range_right_i,
  input  mrdps_pkg::cmd_t               cmd_i,
  output mrdps_pkg::status_t            status_o,
  output logic signed [mrdps_pkg::ResW-1:0] min_queries_o
);
  import mrdps_pkg::*;

  localparam cnt_t NMaxC = cnt_t'(MaxElements);
  localparam cnt_t QMaxC = cnt_t'(MaxQueries);

  // Memories
  value_t elem_mem [MaxElements];
  query_t qry_mem  [MaxQueries];
  sum_t   diff_mem [DiffDepth];

  value_t elem_rd_q;
  query_t qry_rd_q;
  sum_t   diff_rd_q;

  // Registers
  cnt_t   num_elem_q, num_qry_q;
  res_t   lo_q, hi_q, best_q;
  res_t   lo_d, hi_d, best_d;
  cnt_t   mid_q, mid_d;
  cnt_t   cnt_q, cnt_d;
  sum_t   sum_q, sum_d;
  logic   fail_q, fail_d;
  logic   scan_vld_q, scan_vld_d;
  cnt_t   l_q, r1_q;
  value_t amt_q;
  res_t   result_q;

  // Combinational helpers
  logic [ResW:0] mid_sum;
  logic          q_skip;
  cnt_t          q_r1;
  cnt_t          cfg_sat;
  sum_t          amt_ext;
  sum_t          scan_sum;
  sum_t          scan_chk;
  logic          scan_issue;
  logic          diff_we;
  cnt_t          diff_wa;
  sum_t          diff_wd;
  logic          diff_re;
  cnt_t          diff_ra;
  res_t          mid_ext;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_ext = res_t'({1'b0, mid_q});

  // Query clipping against the elements in use
  assign q_skip = (qry_rd_q.left > qry_rd_q.right) ||
                  ({1'b0, qry_rd_q.left} >= num_elem_q);
  assign q_r1   = ({1'b0, qry_rd_q.right} >= num_elem_q) ? num_elem_q
                                                         : {1'b0, qry_rd_q.right} + cnt_t'(1);

  assign cfg_sat  = (cfg_data_i > NMaxC) ? NMaxC : cfg_data_i;
  assign amt_ext  = sum_t'({{(SumW-ValueW){1'b0}}, amt_q});
  assign scan_sum = sum_q + diff_rd_q;
  assign scan_chk = sum_t'({{(SumW-ValueW){1'b0}}, elem_rd_q}) + scan_sum;
  assign scan_issue = (cmd_i.op == OP_SCAN) && (cnt_q != num_elem_q);

  assign status_o.bound_ok     = (lo_q <= hi_q);
  assign status_o.clear_done   = (cnt_q == num_elem_q);
  assign status_o.queries_done = (cnt_q == mid_q);
  assign status_o.skip         = q_skip;
  assign status_o.scan_done    = (cnt_q == num_elem_q) && !scan_vld_q;

  assign min_queries_o = result_q;

  // Difference memory port selection
  always_comb begin
    diff_we = 1'b0;
    diff_wa = cnt_q;
    diff_wd = '0;
    diff_re = 1'b0;
    diff_ra = cnt_q;
    case (cmd_i.op)
      OP_CLEAR: begin
        diff_we = 1'b1;
      end
      OP_LREAD: begin
        diff_re = 1'b1;
        diff_ra = l_q;
      end
      OP_LWRITE: begin
        diff_we = 1'b1;
        diff_wa = l_q;
        diff_wd = diff_rd_q - amt_ext;
      end
      OP_RREAD: begin
        diff_re = 1'b1;
        diff_ra = r1_q;
      end
      OP_RWRITE: begin
        diff_we = 1'b1;
        diff_wa = r1_q;
        diff_wd = diff_rd_q + amt_ext;
      end
      OP_SCAN: begin
        diff_re = scan_issue;
      end
      default: begin
        diff_we = 1'b0;
      end
    endcase
  end

  // Search and scan control next values
  always_comb begin
    lo_d       = lo_q;
    hi_d       = hi_q;
    best_d     = best_q;
    mid_d      = mid_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    fail_d     = fail_q;
    scan_vld_d = 1'b0;
    case (cmd_i.op)
      OP_INIT: begin
        lo_d   = '0;
        hi_d   = res_t'({1'b0, num_qry_q});
        best_d = '1;
      end
      OP_MID: begin
        mid_d = mid_sum[CntW:1];
        cnt_d = '0;
      end
      OP_CLEAR: begin
        cnt_d = (cnt_q == num_elem_q) ? cnt_t'(0) : cnt_q + cnt_t'(1);
      end
      OP_QSTAGE: begin
        if (q_skip) begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      OP_RWRITE: begin
        cnt_d = cnt_q + cnt_t'(1);
      end
      OP_SCAN_START: begin
        cnt_d  = '0;
        sum_d  = '0;
        fail_d = 1'b0;
      end
      OP_SCAN: begin
        if (scan_issue) begin
          cnt_d      = cnt_q + cnt_t'(1);
          scan_vld_d = 1'b1;
        end
        if (scan_vld_q) begin
          sum_d = scan_sum;
          if (scan_chk > 0) begin
            fail_d = 1'b1;
          end
        end
      end
      OP_UPDATE: begin
        if (!fail_q) begin
          best_d = mid_ext;
          hi_d   = mid_ext - res_t'(1);
        end else begin
          lo_d = mid_ext + res_t'(1);
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_elem_q <= cnt_t'(1);
      num_qry_q  <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      best_q     <= '0;
      mid_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      fail_q     <= 1'b0;
      scan_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NUM_ELEMENTS: num_elem_q <= cfg_sat;
          CFG_NUM_QUERIES:  num_qry_q  <= (cfg_data_i > QMaxC) ? QMaxC : cfg_data_i;
          default:          num_qry_q  <= num_qry_q;
        endcase
      end
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      best_q     <= best_d;
      mid_q      <= mid_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      fail_q     <= fail_d;
      scan_vld_q <= scan_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_QSTAGE) begin
      l_q   <= {1'b0, qry_rd_q.left};
      r1_q  <= q_r1;
      amt_q <= qry_rd_q.amount;
    end
    if (cmd_i.op == OP_RESULT) begin
      result_q <= best_q;
    end
  end

  // Element and query stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_e'(kind_i) == KIND_LOAD_ELEM)) begin
      elem_mem[slot_i] <= value_i;
    end
    if (scan_issue) begin
      elem_rd_q <= elem_mem[cnt_q[SlotW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_e'(kind_i) == KIND_LOAD_QUERY)) begin
      qry_mem[slot_i] <= '{left: range_left_i, right: range_right_i, amount: value_i};
    end
    if (cmd_i.op == OP_QREAD) begin
      qry_rd_q <= qry_mem[cnt_q[SlotW-1:0]];
    end
  end

  // Difference store
  always_ff @(posedge clk_i) begin
    if (diff_we) begin
      diff_mem[diff_wa] <= diff_wd;
    end
    if (diff_re) begin
      diff_rd_q <= diff_mem[diff_ra];
    end
  end

endmodule

// ===== rtl/core/min_range_decrement_prefix_search.sv =====
// Top level of the min range decrement prefix search block.
//
// Requests arrive on a valid/ready channel: kind 0 writes an element demand
// at slot, kind 1 writes a range query (left, right, amount) at slot, kind 2
// starts a search and kind 3 is ignored. Loads give no result. A start
// request gives one result, min_queries: the smallest count of leading
// queries that drives every demand in use to zero, or -1. num_elements
// and num_queries are set on the write port; the user must do so only while
// idle, as the block does not enforce it. Values above 1024 saturate.
// A search checks about log2(Q+1)+1 candidates k. Each check clears the
// difference store entries 0..N, applies the first k queries (an empty
// query is only read and staged, a live one does a read-modify-write of
// two difference entries, one store access at a time), then streams the
// prefix scan and updates the search bounds. Access to the difference
// store sets the pace. No request is accepted during a search.
// The result sits in an output register; loads are accepted while it waits.
// A new search can finish only once the previous result is taken.
// Reset sets num_elements to 1, num_queries to 0, and clears all control
// state; stored demands and queries are undefined until written.
module min_range_decrement_prefix_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrdps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mrdps_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mrdps_pkg::KindW-1:0]   kind_i,
  input  logic [mrdps_pkg::SlotW-1:0]   slot_i,
  input  logic [mrdps_pkg::ValueW-1:0]  value_i,
  input  logic [mrdps_pkg::SlotW-1:0]   range_left_i,
  input  logic [mrdps_pkg::SlotW-1:0]   range_right_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [mrdps_pkg::ResW-1:0] min_queries_o
);
  import mrdps_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller
  mrdps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  mrdps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .value_i       (value_i),
    .range_left_i  (range_left_i),
    .range_right_i (range_right_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .min_queries_o (min_queries_o)
  );

endmodule

// ===== tb/min_range_decrement_prefix_search_tb.sv =====
// Testbench for the min range decrement prefix search block: directed and random requests.
`timescale 1ns / 100ps

module min_range_decrement_prefix_search_tb;
  import mrdps_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned ItemTarget = 700;

  logic   clk = 1'b0;
  logic   rst_ni;
  logic   cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic   in_valid_i;
  logic   in_ready_o;
  logic [KindW-1:0]   kind_i;
  slot_t  slot_i;
  value_t value_i;
  slot_t  range_left_i;
  slot_t  range_right_i;
  logic   out_valid_o;
  logic   out_ready_i;
  res_t   min_queries_o;

  // Mirror of the block's stores and registers
  value_t demand_mem [MaxElements];
  bit     demand_set [MaxElements];
  query_t query_mem  [MaxQueries];
  bit     query_set  [MaxQueries];
  cnt_t   cfg_elements = cnt_t'(1);
  cnt_t   cfg_queries  = cnt_t'(0);

  res_t        pending_min_queries [$];
  res_t        oldest_min_queries;
  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  int unsigned demand_style = 0;

  min_range_decrement_prefix_search i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .value_i       (value_i),
    .range_left_i  (range_left_i),
    .range_right_i (range_right_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .min_queries_o (min_queries_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("min_range_decrement_prefix_search: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned live_elements();
    return (cfg_elements > MaxElements) ? MaxElements : int'(cfg_elements);
  endfunction

  function automatic int unsigned live_queries();
    return (cfg_queries > MaxQueries) ? MaxQueries : int'(cfg_queries);
  endfunction

  // True when the first k queries bring every demand in use down to zero
  function automatic bit prefix_clears(int unsigned k);
    longint      delta [DiffDepth];
    longint      acc;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    n = live_elements();
    foreach (delta[i]) delta[i] = 0;
    for (int unsigned i = 0; i < k; i++) begin
      lo = query_mem[i].left;
      hi = query_mem[i].right;
      if (lo > hi || lo >= n) continue;
      if (hi >= n) hi = n - 1;
      delta[lo]   -= longint'(query_mem[i].amount);
      delta[hi+1] += longint'(query_mem[i].amount);
    end
    acc = 0;
    for (int unsigned i = 0; i < n; i++) begin
      acc += delta[i];
      if (longint'(demand_mem[i]) + acc > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Binary search over the query count, -1 when no prefix works
  function automatic res_t smallest_clearing_prefix();
    longint lo;
    longint hi;
    longint mid;
    longint best;
    best = -1;
    lo   = 0;
    hi   = live_queries();
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (prefix_clears(int'(mid))) begin
        best = mid;
        hi   = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return res_t'(best);
  endfunction

  // ---------------------------------------------------------------------------
  // Random pickers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t pick_demand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    case (demand_style)
      0:       return value_t'($urandom_range(0, 3));
      1:       return value_t'($urandom);
      default: return (r < 20) ? value_t'($urandom_range(1, 2)) : value_t'(0);
    endcase
  endfunction

  function automatic value_t pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '1;
    case (demand_style)
      0:       return value_t'($urandom_range(0, 6));
      1:       return value_t'($urandom);
      default: return value_t'($urandom_range(0, 2));
    endcase
  endfunction

  // Index mostly near the elements in use, sometimes anywhere
  function automatic slot_t pick_index();
    int unsigned top;
    top = live_elements() + 1;
    if (top > MaxElements - 1) top = MaxElements - 1;
    if ($urandom_range(0, 99) < 80) return slot_t'($urandom_range(0, top));
    return slot_t'($urandom_range(0, MaxElements - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Sends one request; entered and left at a falling edge, valid left as is
  task automatic send_request(kind_e kind, slot_t slot, value_t value, slot_t left,
                              slot_t right);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    slot_i        <= slot;
    value_i       <= value;
    range_left_i  <= left;
    range_right_i <= right;
    do @(posedge clk); while (!in_ready_o);
    case (kind)
      KIND_LOAD_ELEM: begin
        demand_mem[slot] = value;
        demand_set[slot] = 1'b1;
      end
      KIND_LOAD_QUERY: begin
        query_mem[slot] = '{left: left, right: right, amount: value};
        query_set[slot] = 1'b1;
      end
      KIND_START: pending_min_queries.push_back(smallest_clearing_prefix());
      default: ;
    endcase
    if (kind != KIND_NONE) sent_items++;
    @(negedge clk);
  endtask

  task automatic load_demand(int unsigned slot, value_t value);
    send_request(KIND_LOAD_ELEM, slot_t'(slot), value, slot_t'($urandom), slot_t'($urandom));
  endtask

  task automatic load_query(int unsigned slot, int unsigned left, int unsigned right,
                            value_t amount);
    send_request(KIND_LOAD_QUERY, slot_t'(slot), amount, slot_t'(left), slot_t'(right));
  endtask

  task automatic load_random_query(int unsigned slot);
    slot_t left;
    slot_t right;
    left = pick_index();
    if ($urandom_range(0, 99) < 70) begin
      right = slot_t'(left + $urandom_range(0, live_elements()));
      if (right < left) right = '1;
    end else begin
      right = pick_index();
    end
    load_query(slot, left, right, pick_amount());
  endtask

  // Loads any entry a search would read but that was never written, then starts
  task automatic start_search();
    for (int unsigned i = 0; i < live_elements(); i++)
      if (!demand_set[i]) load_demand(i, pick_demand());
    for (int unsigned i = 0; i < live_queries(); i++)
      if (!query_set[i]) load_random_query(i);
    send_request(KIND_START, slot_t'($urandom), value_t'($urandom), slot_t'($urandom),
                 slot_t'($urandom));
  endtask

  // Drains every pending result and lets the block settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_min_queries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes both registers while idle
  task automatic configure(cnt_t elements, cnt_t queries);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NUM_ELEMENTS;
    cfg_data_i <= elements;
    @(negedge clk);
    cfg_idx_i  <= CFG_NUM_QUERIES;
    cfg_data_i <= queries;
    @(negedge clk);
    cfg_we_i   <= 1'b0;
    cfg_elements = elements;
    cfg_queries  = queries;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_min_queries.size() == 0) begin
        $display("%0t: min_queries expected none, got %0d", $time, min_queries_o);
        mismatches++;
      end else begin
        oldest_min_queries = pending_min_queries.pop_front();
        if (min_queries_o !== oldest_min_queries) begin
          $display("%0t: min_queries expected %0d, got %0d", $time, oldest_min_queries,
                   min_queries_o);
          mismatches++;
        end
      end
    end
  end

  // Result side back-pressure: runs of ready with stalls in between
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk);
    forever begin
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 10))
        @(negedge clk);
      case ($urandom_range(0, 9))
        0, 1:    ;
        2:       begin out_ready_i <= 1'b0; repeat ($urandom_range(20, 80)) @(negedge clk); end
        default: begin out_ready_i <= 1'b0; repeat ($urandom_range(1, 3)) @(negedge clk); end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One element, no queries: the answer depends only on the lone demand
  task automatic test_reset_state();
    load_demand(0, '0);
    start_search();
    load_demand(0, value_t'(1));
    start_search();
    load_demand(0, '1);
    start_search();
  endtask

  // Empty, clipped and out-of-range queries, unknown kind, no elements in use
  task automatic test_query_shapes();
    configure(cnt_t'(4), cnt_t'(6));
    load_demand(0, value_t'(5));
    load_demand(1, value_t'(0));
    load_demand(2, value_t'(5));
    load_demand(3, value_t'(5));
    load_query(0, 3, 1, value_t'(50));        // left above right
    load_query(1, 2, 1023, value_t'(2));      // clipped to the elements in use
    load_query(2, 9, 20, '1);                 // starts past the elements
    load_query(3, 0, 3, value_t'(3));
    load_query(4, 0, 0, value_t'(2));
    load_query(5, 1023, 1023, '1);
    start_search();
    send_request(KIND_NONE, '1, '1, '1, '1);
    start_search();
    configure(cnt_t'(4), cnt_t'(4));
    start_search();
    configure(cnt_t'(0), cnt_t'(6));
    start_search();
    // widest demand cleared only by the widest amount
    load_demand(3, '1);
    load_query(5, 3, 3, '1);
    configure(cnt_t'(4), cnt_t'(6));
    start_search();
  endtask

  // Wide stores with long queries clipped at the last element in use
  task automatic test_wide_stores();
    demand_style = 0;
    configure(cnt_t'(256), cnt_t'(128));
    for (int unsigned i = 0; i < 256; i++) load_demand(i, value_t'($urandom_range(0, 7)));
    for (int unsigned i = 0; i < 128; i++)
      load_query(i, $urandom_range(0, 255), 1023, value_t'($urandom_range(0, 3)));
    start_search();
    configure(cnt_t'(255), cnt_t'(128));
    start_search();
  endtask

  // Phases of random settings, each a run of loads, searches and noise
  task automatic test_random_phases();
    int unsigned r;
    int unsigned n;
    int unsigned q;
    while (sent_items < ItemTarget) begin
      r = $urandom_range(0, 99);
      n = (r < 5) ? 0 : (r < 70) ? $urandom_range(1, 16) :
          (r < 92) ? $urandom_range(17, 64) : $urandom_range(65, 300);
      r = $urandom_range(0, 99);
      q = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 16) : $urandom_range(17, 48);
      configure(cnt_t'(n), cnt_t'(q));
      gaps_on      = ($urandom_range(0, 4) != 0);
      demand_style = $urandom_range(0, 2);
      repeat ($urandom_range(4, 30)) begin
        r = $urandom_range(0, 99);
        if (r < 38)
          load_demand($urandom_range(0, (n > 0) ? n - 1 : 0), pick_demand());
        else if (r < 76)
          load_random_query($urandom_range(0, (q > 0) ? q - 1 : 0));
        else if (r < 88)
          start_search();
        else if (r < 94)
          send_request(KIND_NONE, slot_t'($urandom), value_t'($urandom), slot_t'($urandom),
                       slot_t'($urandom));
        else
          send_request(($urandom_range(0, 1) != 0) ? KIND_LOAD_ELEM : KIND_LOAD_QUERY,
                       slot_t'($urandom), value_t'($urandom), slot_t'($urandom),
                       slot_t'($urandom));
      end
      start_search();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_NUM_ELEMENTS;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_NONE;
    slot_i        = '0;
    value_i       = '0;
    range_left_i  = '0;
    range_right_i = '0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_query_shapes();
    test_wide_stores();
    test_random_phases();

    quiesce();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("min_range_decrement_prefix_search: match");
    end else begin
      $display("min_range_decrement_prefix_search: mismatch");
    end
    $finish;
  end

endmodule
